### sv/lph_pkg.sv
`default_nettype none

package lph_pkg;

	localparam int CAPACITY = 256;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 9;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 32;

	localparam logic [KEY_W-1:0]  KEY_UNUSED     = '0;
	localparam logic [KEY_W-1:0]  KEY_GRAVE      = 64'h0000_0000_FFFF_FFFF;
	localparam logic [VAL_W-1:0]  NO_VALUE       = '1;
	localparam logic [CNT_W-1:0]  FILL_LIMIT_RST = 9'd192;
	localparam logic [SLOT_W-1:0] PROBE_LAST     = SLOT_W'(CAPACITY - 1);

	typedef enum logic [1:0] {
		FN_GET    = 2'd0,
		FN_SET    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_NO_ROOM = 2'd2,
		STAT_BAD_KEY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_BACK,
		ST_OUT
	} state_t;

	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  read_value;
		status_t           status;
		logic              over_fill;
		logic [CNT_W-1:0]  used_entries;
		logic [CNT_W-1:0]  tombstone_entries;
	} out_item_t;

endpackage

`default_nettype wire

### sv/lph_ram.sv
`default_nettype none

module lph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/linear_probe_hash_table.sv
// sequence: an accepted word probes slots from its home slot until a hit, a free slot or
// the last slot; a remove that frees its slot then sweeps back over the tombstones behind it;
// clear and bad key go straight to the output register, which a held out_ready delays.
// throughput: one word at a time, set by the single key ram read port, which visits one
// slot per cycle; a new word is taken only in the idle state after the last is output.
// reset: asynchronous, clears slot valid bits, counts and handshakes and sets the fill
// limit to 192 at once; no clearing pass, the table is ready as soon as reset is released.
`default_nettype none

module linear_probe_hash_table (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire lph_pkg::in_item_t        in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output lph_pkg::out_item_t            out_data,
	input  wire logic                     cfg_we,
	input  wire logic [lph_pkg::CNT_W-1:0] cfg_wdata
);

	import lph_pkg::*;

	state_t              state_q, state_d;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    live_q, grave_q, fill_limit_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	func_t               func_q;
	logic [SLOT_W-1:0]   addr_q, probes_q;
	logic [VAL_W-1:0]    res_rd_q;
	status_t             res_status_q;
	logic                res_over_q;

	logic [KEY_W-1:0]    key_rdata, slot_key, key_wdata;
	logic [VAL_W-1:0]    val_rdata;
	logic [SLOT_W-1:0]   rd_addr, addr_inc, addr_dec;
	logic                key_we, val_we, out_load, in_fire, in_reserved;
	logic                slot_used, nxt_used, is_hit, is_stop, is_last, is_grave;
	logic                do_clear, do_set, do_rm, do_unbury;
	logic [CNT_W:0]      over_sum;

	assign addr_inc    = addr_q + SLOT_W'(1);
	assign addr_dec    = addr_q - SLOT_W'(1);
	assign slot_used   = valid_q[addr_q];
	assign nxt_used    = valid_q[addr_inc];
	assign slot_key    = slot_used ? key_rdata : KEY_UNUSED;
	assign is_hit      = (slot_key == key_q);
	assign is_stop     = is_hit || !slot_used;
	assign is_last     = (probes_q == PROBE_LAST);
	assign is_grave    = slot_used && (key_rdata == KEY_GRAVE);
	assign in_fire     = in_valid && in_ready;
	assign in_reserved = (in_data.key == KEY_UNUSED) || (in_data.key == KEY_GRAVE);
	assign over_sum    = (CNT_W+1)'(live_q) + (CNT_W+1)'(grave_q) + (CNT_W+1)'(1);

	lph_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (addr_q),
		.wdata (key_wdata),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lph_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (addr_q),
		.wdata (value_q),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.func == FN_CLEAR || in_reserved) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (is_stop) begin
					if (func_q == FN_REMOVE && is_hit && !nxt_used) begin
						state_d = ST_BACK;
					end else begin
						state_d = ST_OUT;
					end
				end else if (is_last) begin
					state_d = ST_OUT;
				end
			end
			ST_BACK: begin
				if (!is_grave || is_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and ram control
	always_comb begin
		in_ready  = 1'b0;
		rd_addr   = addr_inc;
		key_we    = 1'b0;
		key_wdata = key_q;
		val_we    = 1'b0;
		out_load  = 1'b0;
		do_clear  = 1'b0;
		do_set    = 1'b0;
		do_rm     = 1'b0;
		do_unbury = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_data.key[SLOT_W-1:0];
				do_clear = in_fire && (in_data.func == FN_CLEAR);
			end
			ST_PROBE: begin
				if (is_stop && func_q == FN_SET) begin
					do_set = 1'b1;
					key_we = 1'b1;
					val_we = 1'b1;
				end
				if (is_stop && is_hit && func_q == FN_REMOVE) begin
					do_rm = 1'b1;
					if (nxt_used) begin
						key_we    = 1'b1;
						key_wdata = KEY_GRAVE;
					end else begin
						// start the backward tombstone sweep
						rd_addr = addr_dec;
					end
				end
			end
			ST_BACK: begin
				rd_addr   = addr_dec;
				do_unbury = is_grave;
			end
			ST_OUT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			live_q       <= '0;
			grave_q      <= '0;
			fill_limit_q <= FILL_LIMIT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				fill_limit_q <= cfg_wdata;
			end
			if (do_clear) begin
				valid_q <= '0;
				live_q  <= '0;
				grave_q <= '0;
			end
			if (do_set) begin
				valid_q[addr_q] <= 1'b1;
				if (!slot_used) begin
					live_q <= live_q + CNT_W'(1);
				end
			end
			if (do_rm) begin
				if (live_q != '0) begin
					live_q <= live_q - CNT_W'(1);
				end
				if (nxt_used) begin
					grave_q <= grave_q + CNT_W'(1);
				end else begin
					valid_q[addr_q] <= 1'b0;
				end
			end
			if (do_unbury) begin
				valid_q[addr_q] <= 1'b0;
				if (grave_q != '0) begin
					grave_q <= grave_q - CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q        <= in_data.key;
			value_q      <= in_data.value;
			func_q       <= in_data.func;
			addr_q       <= in_data.key[SLOT_W-1:0];
			probes_q     <= '0;
			res_rd_q     <= NO_VALUE;
			res_over_q   <= 1'b0;
			res_status_q <= (in_data.func != FN_CLEAR && in_reserved) ? STAT_BAD_KEY : STAT_OK;
		end
		if (state_q == ST_PROBE) begin
			if (is_stop) begin
				unique case (func_q)
					FN_GET: begin
						if (is_hit) begin
							res_rd_q <= val_rdata;
						end else begin
							res_status_q <= STAT_MISSING;
						end
					end
					FN_SET: begin
						res_over_q <= !slot_used && (over_sum > (CNT_W+1)'(fill_limit_q));
					end
					FN_REMOVE: begin
						if (!is_hit) begin
							res_status_q <= STAT_MISSING;
						end else if (!nxt_used) begin
							addr_q   <= addr_dec;
							probes_q <= '0;
						end
					end
					default: ;
				endcase
			end else if (is_last) begin
				res_status_q <= (func_q == FN_SET) ? STAT_NO_ROOM : STAT_MISSING;
			end else begin
				addr_q   <= addr_inc;
				probes_q <= probes_q + SLOT_W'(1);
			end
		end
		if (do_unbury) begin
			addr_q   <= addr_dec;
			probes_q <= probes_q + SLOT_W'(1);
		end
		if (out_load) begin
			out_data_q.read_value        <= res_rd_q;
			out_data_q.status            <= res_status_q;
			out_data_q.over_fill         <= res_over_q;
			out_data_q.used_entries      <= live_q;
			out_data_q.tombstone_entries <= grave_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lph_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 6000;
	localparam int POOL_N      = 24;
	localparam int SETTLE      = 8;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	in_item_t        in_data   = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	out_item_t       out_data;
	logic            cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// shadow copy of the table
	logic [KEY_W-1:0] shadow_key [CAPACITY];
	logic [VAL_W-1:0] shadow_val [CAPACITY];
	int               shadow_live;
	int               shadow_graves;
	int               shadow_limit;

	in_item_t  pending_ops [$];
	out_item_t lookup_results [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	logic in_taken = 1'b0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   hold_req = 0;
	int   hold_ack = 0;
	int   hold_left = 0;
	int   stall_cnt = 0;
	int   mismatches = 0;
	int   words_in = 0;
	int   words_out = 0;
	int   over_hits = 0;
	int   status_hits [4] = '{0, 0, 0, 0};

	linear_probe_hash_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic void table_wipe();
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_key[i] = KEY_UNUSED;
			shadow_val[i] = NO_VALUE;
		end
		shadow_live   = 0;
		shadow_graves = 0;
	endfunction

	function automatic out_item_t table_apply(in_item_t op);
		out_item_t         res;
		logic [SLOT_W-1:0] idx;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] nxt;
		logic              found;
		res.read_value = NO_VALUE;
		res.status     = STAT_OK;
		res.over_fill  = 1'b0;
		found = 1'b0;
		slot  = '0;
		if (op.func == FN_CLEAR) begin
			table_wipe();
		end else if (op.key == KEY_UNUSED || op.key == KEY_GRAVE) begin
			res.status = STAT_BAD_KEY;
		end else begin
			idx = SLOT_W'(op.key % CAPACITY);
			// forward walk, tombstones are passed over
			for (int n = 0; n < CAPACITY && !found; n++) begin
				if (shadow_key[idx] == op.key || shadow_key[idx] == KEY_UNUSED) begin
					found = 1'b1;
					slot  = idx;
				end else begin
					idx = (idx == PROBE_LAST) ? '0 : idx + 1'b1;
				end
			end
			case (op.func)
				FN_GET: begin
					if (found && shadow_key[slot] == op.key)
						res.read_value = shadow_val[slot];
					else
						res.status = STAT_MISSING;
				end
				FN_SET: begin
					if (!found) begin
						res.status = STAT_NO_ROOM;
					end else begin
						if (shadow_key[slot] == KEY_UNUSED) begin
							shadow_live++;
							if (shadow_live + shadow_graves > shadow_limit)
								res.over_fill = 1'b1;
						end
						shadow_key[slot] = op.key;
						shadow_val[slot] = op.value;
					end
				end
				FN_REMOVE: begin
					if (!found || shadow_key[slot] != op.key) begin
						res.status = STAT_MISSING;
					end else begin
						nxt = (slot == PROBE_LAST) ? '0 : slot + 1'b1;
						if (shadow_key[nxt] != KEY_UNUSED) begin
							shadow_key[slot] = KEY_GRAVE;
							shadow_graves++;
						end else begin
							shadow_key[slot] = KEY_UNUSED;
							// sweep the tombstone run behind the freed slot, wrapping
							idx = (slot == '0) ? PROBE_LAST : slot - 1'b1;
							for (int n = 0; n < CAPACITY && shadow_key[idx] == KEY_GRAVE; n++) begin
								shadow_key[idx] = KEY_UNUSED;
								if (shadow_graves > 0)
									shadow_graves--;
								idx = (idx == '0) ? PROBE_LAST : idx - 1'b1;
							end
						end
						if (shadow_live > 0)
							shadow_live--;
					end
				end
				default: ;
			endcase
		end
		res.used_entries      = CNT_W'(shadow_live);
		res.tombstone_entries = CNT_W'(shadow_graves);
		return res;
	endfunction

	function automatic in_item_t random_op();
		in_item_t op;
		int       r;
		r = $urandom_range(99);
		op.value = $urandom;
		op.key   = key_pool[$urandom_range(POOL_N - 1)];
		op.func  = FN_SET;
		if (r < 2) begin
			op.func = FN_CLEAR;
			op.key  = {$urandom, $urandom};
		end else if (r < 5) begin
			op.func = func_t'($urandom_range(2));
			op.key  = ($urandom_range(1) == 1) ? KEY_GRAVE : KEY_UNUSED;
		end else if (r < 12) begin
			op.func = func_t'($urandom_range(2));
			op.key  = {$urandom, $urandom};
		end else if (r < 50) begin
			op.func = FN_SET;
		end else if (r < 75) begin
			op.func = FN_GET;
		end else begin
			op.func = FN_REMOVE;
		end
		return op;
	endfunction

	// keys cluster on a few home slots so probe chains and tombstones build up
	task automatic reseed_pool();
		logic [SLOT_W-1:0] base [3];
		logic [KEY_W-1:0]  k;
		for (int j = 0; j < 3; j++)
			base[j] = SLOT_W'($urandom);
		for (int j = 0; j < POOL_N; j++) begin
			k = {$urandom, $urandom};
			k[SLOT_W-1:0] = base[j % 3] + SLOT_W'($urandom_range(1));
			key_pool[j] = k;
		end
	endtask

	task automatic push_op(func_t f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		in_item_t op;
		op.func  = f;
		op.key   = k;
		op.value = v;
		pending_ops.push_back(op);
	endtask

	task automatic push_random(int count);
		repeat (count)
			pending_ops.push_back(random_op());
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || in_valid || lookup_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_fill(int v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = CNT_W'(v);
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// driver: one assignment per signal per falling edge
	always @(negedge clk) begin : driver
		logic     nv;
		in_item_t nd;
		nv = in_valid;
		nd = in_data;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_valid || in_taken) begin
			nv = 1'b0;
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
				nd = pending_ops.pop_front();
				nv = 1'b1;
			end
		end
		in_valid <= nv;
		in_data  <= nd;
	end

	always @(negedge clk) begin : receiver
		if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		logic      in_fire;
		logic      out_fire;
		in_fire  = (arst_n && in_valid && in_ready) === 1'b1;
		out_fire = (arst_n && out_valid && out_ready) === 1'b1;
		in_taken  <= in_fire;
		stall_cnt <= (in_fire || out_fire) ? 0 : stall_cnt + 1;
		if (arst_n && cfg_we)
			shadow_limit = int'(cfg_wdata);
		if (in_fire) begin
			lookup_results.push_back(table_apply(in_data));
			words_in++;
		end
		if (out_fire) begin
			words_out++;
			status_hits[out_data.status]++;
			over_hits += out_data.over_fill;
			if (lookup_results.size() == 0) begin
				if (mismatches < 10)
					$display("word %0d arrived with nothing expected: rd=%h st=%0d of=%b used=%0d tomb=%0d",
						words_out, out_data.read_value, out_data.status, out_data.over_fill,
						out_data.used_entries, out_data.tombstone_entries);
				mismatches++;
			end else begin
				want = lookup_results.pop_front();
				if (out_data.read_value !== want.read_value || out_data.status !== want.status
						|| out_data.over_fill !== want.over_fill
						|| out_data.used_entries !== want.used_entries
						|| out_data.tombstone_entries !== want.tombstone_entries) begin
					if (mismatches < 10) begin
						$display("word %0d expected rd=%h st=%0d of=%b used=%0d tomb=%0d",
							words_out, want.read_value, want.status, want.over_fill,
							want.used_entries, want.tombstone_entries);
						$display("word %0d got      rd=%h st=%0d of=%b used=%0d tomb=%0d",
							words_out, out_data.read_value, out_data.status, out_data.over_fill,
							out_data.used_entries, out_data.tombstone_entries);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		while (stall_cnt < STALL_LIMIT)
			@(posedge clk);
		$display("linear_probe_hash_table: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [KEY_W-1:0] fill_keys [CAPACITY];
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
		logic [KEY_W-1:0] kc;
		logic [KEY_W-1:0] k;
		ka = 64'hFFFF_FFFF_FFFF_FFFF;
		kb = 64'h0000_0001_0000_00FF;
		kc = 64'h8000_0000_0000_01FF;
		table_wipe();
		shadow_limit = int'(FILL_LIMIT_RST);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reserved keys, wrap-around chain, tombstone sweep across slot 0
		send_idle = 17;
		recv_idle = 56;
		push_op(FN_GET,    ka, $urandom);
		push_op(FN_GET,    KEY_UNUSED, $urandom);
		push_op(FN_SET,    KEY_UNUSED, $urandom);
		push_op(FN_REMOVE, KEY_GRAVE, $urandom);
		push_op(FN_GET,    KEY_GRAVE, $urandom);
		push_op(FN_SET,    ka, '0);
		push_op(FN_SET,    kb, '1);
		push_op(FN_SET,    kc, $urandom);
		push_op(FN_GET,    kb, $urandom);
		push_op(FN_GET,    kc, $urandom);
		push_op(FN_SET,    ka, $urandom);
		push_op(FN_GET,    ka, $urandom);
		push_op(FN_REMOVE, ka, $urandom);
		push_op(FN_GET,    kb, $urandom);
		push_op(FN_REMOVE, kc, $urandom);
		push_op(FN_REMOVE, kb, $urandom);
		push_op(FN_REMOVE, kb, $urandom);
		push_op(FN_SET,    64'h0000_0001_FFFF_FFFF, $urandom);
		push_op(FN_SET,    64'h0000_0000_FFFF_FFFE, $urandom);
		push_op(FN_GET,    64'h0000_0001_FFFF_FFFF, $urandom);
		push_op(FN_CLEAR,  {$urandom, $urandom}, $urandom);
		push_op(FN_GET,    64'h0000_0001_FFFF_FFFF, $urandom);
		drain();

		// lowest limit: a new entry warns unless the table is empty; long receiver hold-off, then a full pause
		write_fill(1);
		reseed_pool();
		push_random(60);
		hold_req++;
		push_random(90);
		drain();
		push_random(150);
		drain();

		// highest limit, table filled to the last slot
		write_fill(CAPACITY);
		send_idle = 56;
		recv_idle = 17;
		push_op(FN_CLEAR, {$urandom, $urandom}, $urandom);
		for (int i = 0; i < CAPACITY; i++) begin
			k = {$urandom | 32'h1, $urandom};
			k[SLOT_W-1:0] = SLOT_W'(i);
			fill_keys[i] = k;
			push_op(FN_SET, k, $urandom);
		end
		k = {$urandom | 32'h1, $urandom};
		push_op(FN_SET,    fill_keys[7], $urandom);
		push_op(FN_SET,    k, $urandom);
		push_op(FN_GET,    k, $urandom);
		push_op(FN_GET,    fill_keys[200], $urandom);
		push_op(FN_REMOVE, fill_keys[10], $urandom);
		k[SLOT_W-1:0] = SLOT_W'(10);
		push_op(FN_SET,    k, $urandom);
		push_op(FN_GET,    fill_keys[11], $urandom);
		push_op(FN_REMOVE, fill_keys[10], $urandom);
		push_op(FN_CLEAR,  {$urandom, $urandom}, $urandom);
		drain();

		write_fill($urandom_range(8, 64));
		reseed_pool();
		push_random(180);
		drain();

		write_fill($urandom_range(1, CAPACITY));
		send_idle = 0;
		recv_idle = 0;
		reseed_pool();
		push_random(180);
		drain();

		repeat (40) @(posedge clk);
		$display("run covered %0d words in and %0d out: ok %0d, missing %0d, no room %0d, bad key %0d",
			words_in, words_out, status_hits[STAT_OK], status_hits[STAT_MISSING],
			status_hits[STAT_NO_ROOM], status_hits[STAT_BAD_KEY]);
		$display("over-fill warnings %0d over fill limits from 1 to %0d, with a full table and a long output stall",
			over_hits, CAPACITY);
		if (mismatches == 0 && lookup_results.size() == 0) begin
			$display("linear_probe_hash_table: match");
		end else begin
			$display("linear_probe_hash_table: mismatch");
		end
		$finish;
	end

endmodule
